// ===== sv/bounded_bag_swap_remove_unit_assert.svh =====
// Assertion macros for the bag unit; clocked on i_clk, disabled in reset.
`ifndef BOUNDED_BAG_SWAP_REMOVE_UNIT_ASSERT_SVH
`define BOUNDED_BAG_SWAP_REMOVE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BBSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bbsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsr_pkg
// Shared constants, codes and types of the bounded bag unit.
// ----------------------------------------------------------------------------
package bbsr_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Field widths of the channels
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int SLOT_W = 4;
    localparam int ST_W   = 2;
    localparam int REM_W  = 5;
    localparam int CNTF_W = 5;

    localparam logic [OP_W-1:0] OP_ADD        = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE     = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_ALL = 2'd2;
    localparam logic [OP_W-1:0] OP_READ       = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_word            wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== sv/bbsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbsr_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbsr_ram
    import bbsr_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_word    o_rdata
);

    t_word r_mem [MAX_ITEMS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bounded_bag_swap_remove_unit.sv =====
`timescale 1ns / 1ps
// Flow: add, a full add, an out-of-range read and a remove on an empty bag go straight to
// output; read waits for the registered read data; remove swaps the last entry into a match.
// Throughput: one item at a time; the scan reads one entry per cycle, between swaps, through
// the single read port of the entry store.
// Reset: i_rst_n synchronous, active low; returns to idle, clears the fill count and output valid.
// Entry contents are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
// bounded_bag_swap_remove_unit
// Unordered bag with add, swap-remove, remove-all and indexed read.
// ----------------------------------------------------------------------------
`include "bounded_bag_swap_remove_unit_assert.svh"

module bounded_bag_swap_remove_unit
    import bbsr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [SLOT_W-1:0]        i_slot,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ST_W-1:0]          o_status,
    output logic [REM_W-1:0]         o_removed,
    output logic signed [DATA_W-1:0] o_read_data,
    output logic [CNTF_W-1:0]        o_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SWAP   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [OP_W-1:0]  r_op, n_op;
    t_word            r_value, n_value;
    logic [CNT_W-1:0] r_removed, n_removed;
    logic [ST_W-1:0]  r_status, n_status;
    t_word            r_data, n_data;
    logic             r_fwd, n_fwd;
    t_word            r_fwd_data, n_fwd_data;

    logic              r_out_valid, n_out_valid;
    logic [ST_W-1:0]   r_out_status, n_out_status;
    logic [REM_W-1:0]  r_out_removed, n_out_removed;
    t_word             r_out_data, n_out_data;
    logic [CNTF_W-1:0] r_out_count, n_out_count;

    t_ram_req         w_req;
    t_word            w_rdata;
    t_word            w_cmp_data;
    logic [CNT_W-1:0] w_fill_m1;
    logic [CNT_W-1:0] w_idx_next;
    logic             w_add_take;

    bbsr_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign w_fill_m1  = r_fill - CNT_W'(1);
    assign w_idx_next = CNT_W'(r_idx) + CNT_W'(1);
    // Entry just rewritten by a swap comes from the bypass, not the store
    assign w_cmp_data = r_fwd ? r_fwd_data : w_rdata;
    assign o_ready    = (r_state == S_IDLE);
    assign w_add_take = i_valid && o_ready && i_op == OP_ADD && r_fill != CNT_W'(MAX_ITEMS);

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_idx         = r_idx;
        n_op          = r_op;
        n_value       = r_value;
        n_removed     = r_removed;
        n_status      = r_status;
        n_data        = r_data;
        n_fwd         = r_fwd;
        n_fwd_data    = r_fwd_data;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        n_out_data    = r_out_data;
        n_out_count   = r_out_count;
        w_req.we      = 1'b0;
        w_req.waddr   = r_idx;
        w_req.wdata   = r_value;
        w_req.raddr   = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op      = i_op;
                    n_value   = i_value;
                    n_removed = '0;
                    n_data    = '0;
                    n_status  = ST_OK;
                    n_idx     = '0;
                    n_fwd     = 1'b0;
                    n_state   = S_EMIT;
                    case (i_op)
                        OP_ADD: begin
                            if (r_fill == CNT_W'(MAX_ITEMS)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_req.we    = 1'b1;
                                w_req.waddr = r_fill[IDX_W-1:0];
                                w_req.wdata = i_value;
                                n_fill      = r_fill + CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (CNT_W'(i_slot) < r_fill) begin
                                w_req.raddr = IDX_W'(i_slot);
                                n_state     = S_RDWAIT;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        OP_REMOVE, OP_REMOVE_ALL: begin
                            if (r_fill == '0) begin
                                n_status = ST_NOMATCH;
                            end else begin
                                w_req.raddr = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_SCAN: begin
                n_fwd = 1'b0;
                if (w_cmp_data == r_value) begin
                    // fetch the last entry to move into the hole
                    w_req.raddr = w_fill_m1[IDX_W-1:0];
                    n_state     = S_SWAP;
                end else if (w_idx_next < r_fill) begin
                    n_idx       = w_idx_next[IDX_W-1:0];
                    w_req.raddr = w_idx_next[IDX_W-1:0];
                end else begin
                    n_status = (r_removed == '0) ? ST_NOMATCH : ST_OK;
                    n_state  = S_EMIT;
                end
            end
            S_SWAP: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_idx;
                w_req.wdata = w_rdata;
                n_fill      = w_fill_m1;
                n_removed   = r_removed + CNT_W'(1);
                n_status    = ST_OK;
                // entries below the hole were already checked: rescan from it
                if (r_op == OP_REMOVE_ALL && CNT_W'(r_idx) < w_fill_m1) begin
                    n_fwd      = 1'b1;
                    n_fwd_data = w_rdata;
                    n_state    = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_RDWAIT: begin
                n_data  = w_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_removed = REM_W'(r_removed);
                    n_out_data    = r_data;
                    n_out_count   = CNTF_W'(r_fill);
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_op          <= n_op;
        r_value       <= n_value;
        r_removed     <= n_removed;
        r_status      <= n_status;
        r_data        <= n_data;
        r_fwd_data    <= n_fwd_data;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
        r_out_data    <= n_out_data;
        r_out_count   <= n_out_count;
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_removed   = r_out_removed;
    assign o_read_data = r_out_data;
    assign o_count     = r_out_count;

    `BBSR_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(MAX_ITEMS), "fill above capacity")
    `BBSR_ASSERT_NOW(a_scan_in_range, r_state == S_SCAN, CNT_W'(r_idx) < r_fill, "scan past fill")
    `BBSR_ASSERT_NOW(a_swap_nonempty, r_state == S_SWAP, r_fill != '0, "swap with empty bag")
    `BBSR_ASSERT_NEXT(a_add_grows, w_add_take, r_fill == $past(r_fill) + CNT_W'(1), "add lost")

endmodule

// ===== sim/tb_bounded_bag_swap_remove_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_bag_swap_remove_unit
// Drives add, remove, remove-all and read items into the bag unit under random
// flow control on both sides. Each accepted item is replayed on a local copy
// of the bag. Every returned result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_bounded_bag_swap_remove_unit;
    import bbsr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_ITEMS  = 60;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [SLOT_W-1:0]        slot;
        bit                       drain;
    } t_bag_op;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic [REM_W-1:0]         removed;
        logic signed [DATA_W-1:0] read_data;
        logic [CNTF_W-1:0]        count;
    } t_bag_result;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_ready;
    logic [OP_W-1:0]          i_op        = OP_ADD;
    logic signed [DATA_W-1:0] i_value     = '0;
    logic [SLOT_W-1:0]        i_slot      = '0;
    logic                     o_valid;
    logic                     i_ready     = 1'b0;
    logic [ST_W-1:0]          o_status;
    logic [REM_W-1:0]         o_removed;
    logic signed [DATA_W-1:0] o_read_data;
    logic [CNTF_W-1:0]        o_count;

    bounded_bag_swap_remove_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_slot      (i_slot),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_removed   (o_removed),
        .o_read_data (o_read_data),
        .o_count     (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the bag
    t_word       bag_mem [MAX_ITEMS];
    int          bag_fill = 0;

    t_bag_op     op_backlog[$];
    t_bag_result due_results[$];
    t_bag_op     offered;
    int          items_taken = 0;
    int          tx_gap      = 0;
    int          rx_gap      = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    bit          calm        = 1'b0;
    int          error_cnt   = 0;
    int          cycle_cnt   = 0;

    function automatic bit take_match(t_word v);
        for (int k = 0; k < bag_fill; k++) begin
            if (bag_mem[k] == v) begin
                bag_mem[k] = bag_mem[bag_fill-1];
                bag_fill--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_bag_result bag_apply(t_bag_op it);
        t_bag_result r;
        int          n;
        r.status    = ST_OK;
        r.removed   = '0;
        r.read_data = '0;
        n           = 0;
        case (it.op)
            OP_ADD: begin
                if (bag_fill >= MAX_ITEMS) begin
                    r.status = ST_FULL;
                end else begin
                    bag_mem[bag_fill] = it.value;
                    bag_fill++;
                end
            end
            OP_REMOVE: begin
                if (take_match(it.value)) r.removed = REM_W'(1);
                else r.status = ST_NOMATCH;
            end
            OP_REMOVE_ALL: begin
                while (take_match(it.value)) n++;
                r.removed = n[REM_W-1:0];
                if (n == 0) r.status = ST_NOMATCH;
            end
            default: begin
                if (int'(it.slot) < bag_fill) r.read_data = bag_mem[it.slot];
                else r.status = ST_RANGE;
            end
        endcase
        r.count = bag_fill[CNTF_W-1:0];
        return r;
    endfunction

    task automatic queue_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                            logic [SLOT_W-1:0] slot, bit drain);
        t_bag_op it;
        it.op    = op;
        it.value = value;
        it.slot  = slot;
        it.drain = drain;
        op_backlog.push_back(it);
    endtask

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                due_results.push_back(bag_apply(offered));
                items_taken <= items_taken + 1;
            end
            calm <= (op_backlog.size() < CALM_ITEMS);
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (op_backlog.size() == 0 ||
                             (op_backlog[0].drain && due_results.size() != 0)) begin
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 7);
                    i_valid <= 1'b0;
                end else begin
                    offered = op_backlog.pop_front();
                    i_valid <= 1'b1;
                    i_op    <= offered.op;
                    i_value <= offered.value;
                    i_slot  <= offered.slot;
                end
            end
        end
    end

    // Long receiver hold-off so the unit backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_taken >= 120) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver and checker
    always @(posedge i_clk) begin
        t_bag_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("%0t: unexpected result st=%0d rm=%0d data=%0d cnt=%0d",
                                 $realtime, o_status, o_removed, o_read_data, o_count);
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status || o_removed !== want.removed ||
                        o_read_data !== want.read_data || o_count !== want.count) begin
                        error_cnt++;
                        if (error_cnt <= 10) begin
                            $display("%0t: mismatch exp st=%0d rm=%0d data=%0d cnt=%0d",
                                     $realtime, want.status, want.removed,
                                     want.read_data, want.count);
                            $display("    got st=%0d rm=%0d data=%0d cnt=%0d",
                                     o_status, o_removed, o_read_data, o_count);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                rx_gap = $urandom_range(0, 7);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_word           pool [8];
        int              add_pct;
        logic [OP_W-1:0] op;
        t_word           v;
        int              r;

        // Empty bag: removes miss, read is out of range
        queue_op(OP_REMOVE, 32'sd7, 4'd0, 1'b0);
        queue_op(OP_REMOVE_ALL, 32'sd7, 4'd0, 1'b0);
        queue_op(OP_READ, 32'sd0, 4'd0, 1'b0);
        queue_op(OP_ADD, 32'sh7FFFFFFF, 4'd0, 1'b0);
        queue_op(OP_ADD, 32'sh80000000, 4'd0, 1'b0);
        queue_op(OP_ADD, 32'sh80000000, 4'd0, 1'b0);
        queue_op(OP_ADD, -32'sd1, 4'd0, 1'b0);
        // Lowest match wins, last entry moves into its place
        queue_op(OP_REMOVE, 32'sh80000000, 4'd0, 1'b0);
        queue_op(OP_READ, 32'sd0, 4'd1, 1'b0);
        queue_op(OP_READ, 32'sd0, 4'd3, 1'b0);
        queue_op(OP_REMOVE, -32'sd1, 4'd0, 1'b0);
        // Match sits at the last position
        queue_op(OP_REMOVE, 32'sh80000000, 4'd0, 1'b0);
        queue_op(OP_REMOVE, 32'sh7FFFFFFF, 4'd0, 1'b0);
        // Fill up, overflow, then clear all at once
        for (int k = 0; k < MAX_ITEMS; k++) queue_op(OP_ADD, 32'sh5A5AA5A5, 4'd0, 1'b0);
        queue_op(OP_ADD, 32'sd1, 4'd0, 1'b0);
        queue_op(OP_READ, 32'sd0, 4'd15, 1'b0);
        queue_op(OP_REMOVE_ALL, 32'sh5A5AA5A5, 4'd0, 1'b0);

        pool[0] = 32'h7FFFFFFF;
        pool[1] = 32'h80000000;
        pool[2] = 32'h00000000;
        pool[3] = 32'hFFFFFFFF;
        for (int b = 0; b < 12; b++) begin
            // Small value pool per block so removes hit; add weight swings fill
            for (int k = 4; k < 8; k++) pool[k] = $urandom;
            add_pct = $urandom_range(25, 80);
            for (int k = 0; k < 35; k++) begin
                r = $urandom_range(0, 99);
                if (r < add_pct) op = OP_ADD;
                else if (r < add_pct + (100 - add_pct) / 2) op = OP_REMOVE;
                else if ($urandom_range(0, 1) == 0) op = OP_REMOVE_ALL;
                else op = OP_READ;
                if ($urandom_range(0, 4) == 0) v = $urandom;
                else v = pool[$urandom_range(0, 7)];
                queue_op(op, v, 4'($urandom_range(0, 15)), (k == 0 && (b == 0 || b == 5)));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || i_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && due_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
